// ----- design/ksd_pkg.sv -----
// Shared constants, types and the reciprocal table for the keyword score
// smoother and detector. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

  localparam int SMOOTH_WINDOW = 3;
  localparam int CLASS_CNT     = 11;
  localparam int REJECT_IDX    = 10;
  localparam int SCORE_W       = 8;
  localparam int CLASS_W       = 4;
  localparam int HOLD_W        = 8;

  localparam int HOPS_W = (SMOOTH_WINDOW > 2) ? $clog2(SMOOTH_WINDOW) : 1;
  localparam int HIST_D = (SMOOTH_WINDOW > 1) ? SMOOTH_WINDOW - 1 : 1;
  localparam int SUM_W  = SCORE_W + HOPS_W;

  localparam int RECIP_SH  = 14;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int RECIP_ONE = 2 ** RECIP_SH;
  localparam int RECIP_1   = RECIP_ONE;
  localparam int RECIP_2   = (RECIP_ONE + 1) / 2;
  localparam int RECIP_3   = (RECIP_ONE + 2) / 3;
  localparam int RECIP_4   = (RECIP_ONE + 3) / 4;
  localparam int RECIP_5   = (RECIP_ONE + 4) / 5;
  localparam int RECIP_6   = (RECIP_ONE + 5) / 6;
  localparam int RECIP_7   = (RECIP_ONE + 6) / 7;
  localparam int RECIP_8   = (RECIP_ONE + 7) / 8;

  localparam int TREE_LV = $clog2(CLASS_CNT);
  localparam int TREE_N  = 2 ** TREE_LV;

  localparam int IN_W  = ((CLASS_CNT * SCORE_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + CLASS_W + SCORE_W + 1;
  localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = SCORE_W'(64);
  localparam logic [HOLD_W-1:0]         HOLD_OFF_RST  = HOLD_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_HOLD_OFF  = 1'b1
  } cfg_reg_t;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    logic              take;
    logic [HOPS_W-1:0] hops;
    logic              div_en;
    logic [HOPS_W-1:0] div_hops;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CLASS_W-1:0] idx;
    score_t             score;
  } cand_t;

  // Reciprocal of (hops + 1), rounded up, scaled by 2**RECIP_SH.
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] dm1);
    logic [RECIP_W-1:0] r;
    unique case (dm1)
      3'd0: r = RECIP_W'(RECIP_1);
      3'd1: r = RECIP_W'(RECIP_2);
      3'd2: r = RECIP_W'(RECIP_3);
      3'd3: r = RECIP_W'(RECIP_4);
      3'd4: r = RECIP_W'(RECIP_5);
      3'd5: r = RECIP_W'(RECIP_6);
      3'd6: r = RECIP_W'(RECIP_7);
      3'd7: r = RECIP_W'(RECIP_8);
      default: r = RECIP_W'(RECIP_1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/ksd_lane.sv -----
// One class lane: score history, windowed sum and the truncating divide.
// Depends on ksd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksd_lane import ksd_pkg::*; (
  input  wire logic       clk,
  input  wire score_t     score,
  input  wire lane_ctrl_t ctrl,
  output score_t          avg
);

  score_t                   hist [0:HIST_D-1];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SCORE_W:0]         quo;
  logic [SCORE_W:0]         quo_signed;
  score_t                   avg_next;

  always_comb begin
    sum_next = SUM_W'(score);
    for (int w = 0; w < HIST_D; w++) begin
      if (w < int'(ctrl.hops)) begin
        sum_next = sum_next + SUM_W'(hist[w]);
      end
    end
  end

  always_comb begin
    mag        = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod       = (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(recip(3'(ctrl.div_hops)));
    quo        = prod[RECIP_SH +: SCORE_W+1];
    quo_signed = sum[SUM_W-1] ? (SCORE_W+1)'(-quo) : quo;
    avg_next   = score_t'(quo_signed[SCORE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      hist[0] <= score;
      for (int w = 1; w < HIST_D; w++) begin
        hist[w] <= hist[w-1];
      end
      sum <= sum_next;
    end
    if (ctrl.div_en) begin
      avg <= avg_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ksd_argmax.sv -----
// Registered compare tree that merges the lane averages into the winning class.
// Depends on ksd_pkg; ties resolve to the lowest class index.
`timescale 1ns / 1ps
`default_nettype none

module ksd_argmax import ksd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire score_t avg [0:CLASS_CNT-1],
  output cand_t       best
);

  cand_t lvl [0:TREE_LV][0:TREE_N-1];

  always_comb begin
    lvl = '{default: '{default: '0}};
    for (int i = 0; i < TREE_N; i++) begin
      if (i < CLASS_CNT) begin
        lvl[0][i].idx   = CLASS_W'(i);
        lvl[0][i].score = avg[i];
      end else begin
        lvl[0][i].idx   = CLASS_W'(i);
        lvl[0][i].score = {1'b1, {(SCORE_W-1){1'b0}}};
      end
    end
    for (int l = 0; l < TREE_LV; l++) begin
      for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
        if (lvl[l][2*i+1].score > lvl[l][2*i].score) begin
          lvl[l+1][i] = lvl[l][2*i+1];
        end else begin
          lvl[l+1][i] = lvl[l][2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best <= lvl[TREE_LV][0];
    end
  end

endmodule

`default_nettype wire

// ----- design/kws_score_smooth_detect_core.sv -----
// Top level of the keyword score smoother and detector: stream ports, pipeline
// control, class lanes, argmax merge and the hold-off decision. Depends on ksd_pkg.
//
// The block takes one hop of eleven class scores per transfer and returns one
// result per hop from the output register. It sustains one hop per clock
// when the output side is not stalled: eleven lanes each keep a short score
// history and sum and divide in two registered steps, a registered compare
// tree picks the winner in the third, and the hold-off counter decides in the
// fourth, all in a four-deep pipeline with a ready that each stage passes back
// separately. Configuration writes take effect from the next hop to reach the
// hold-off decision.
`timescale 1ns / 1ps
`default_nettype none

module kws_score_smooth_detect_core import ksd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // score_0 .. score_9, score_unknown, 8 bits each from the lowest bit up
  input  wire logic [IN_W-1:0]       s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // detected, winner_class, winner_score, suppressed from the lowest bit up
  output logic [OUT_W-1:0]           m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  score_t             score_in [0:CLASS_CNT-1];
  score_t             avg      [0:CLASS_CNT-1];
  lane_ctrl_t         lane_ctrl;
  cand_t              best;

  logic               v1, v2, v3;
  logic               free_out, free3, free2, free1;
  logic               accept;
  logic               decide;
  logic [HOPS_W-1:0]  hops_seen;
  logic [HOPS_W-1:0]  hops_s1;

  score_t             threshold;
  logic [HOLD_W-1:0]  hold_off;
  logic [HOLD_W-1:0]  hold_counter;
  logic [HOLD_W-1:0]  hold_counter_next;
  logic               det_next, sup_next;

  logic               out_detected;
  logic [CLASS_W-1:0] out_class;
  score_t             out_score;
  logic               out_suppressed;

  assign free_out = !m_tvalid || m_tready;
  assign free3    = !v3 || free_out;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign s_tready = free1;
  assign accept   = s_tvalid && s_tready;
  assign decide   = v3 && free_out;

  always_comb begin
    for (int c = 0; c < CLASS_CNT; c++) begin
      score_in[c] = score_t'(s_tdata[c*SCORE_W +: SCORE_W]);
    end
  end

  assign lane_ctrl.take     = accept;
  assign lane_ctrl.hops     = hops_seen;
  assign lane_ctrl.div_en   = free2 && v1;
  assign lane_ctrl.div_hops = hops_s1;

  for (genvar c = 0; c < CLASS_CNT; c++) begin : g_lane
    ksd_lane u_lane (
      .clk   (clk),
      .score (score_in[c]),
      .ctrl  (lane_ctrl),
      .avg   (avg[c])
    );
  end

  ksd_argmax u_argmax (
    .clk  (clk),
    .en   (free3 && v2),
    .avg  (avg),
    .best (best)
  );

  always_comb begin
    det_next          = 1'b0;
    sup_next          = 1'b0;
    hold_counter_next = hold_counter;
    if (hold_counter != '0) begin
      sup_next          = 1'b1;
      hold_counter_next = hold_counter - 1'b1;
    end else if (best.idx != CLASS_W'(REJECT_IDX) && best.score > threshold) begin
      det_next          = 1'b1;
      hold_counter_next = hold_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      m_tvalid     <= 1'b0;
      hops_seen    <= '0;
      hold_counter <= '0;
      threshold    <= THRESHOLD_RST;
      hold_off     <= HOLD_OFF_RST;
    end else begin
      if (free1) begin
        v1 <= s_tvalid;
      end
      if (free2) begin
        v2 <= v1;
      end
      if (free3) begin
        v3 <= v2;
      end
      if (free_out) begin
        m_tvalid <= v3;
      end
      if (accept && hops_seen != HOPS_W'(SMOOTH_WINDOW - 1)) begin
        hops_seen <= hops_seen + 1'b1;
      end
      if (decide) begin
        hold_counter <= hold_counter_next;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD: threshold <= score_t'(cfg_data);
          REG_HOLD_OFF:  hold_off  <= HOLD_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hops_s1 <= hops_seen;
    end
    if (decide) begin
      out_detected   <= det_next;
      out_suppressed <= sup_next;
      out_class      <= best.idx;
      out_score      <= best.score;
    end
  end

  assign m_tdata = OUT_W'({out_suppressed, out_score, out_class, out_detected});

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_detected && out_suppressed))
    else $error("detection reported on a suppressed hop");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_detected |-> out_class != CLASS_W'(REJECT_IDX))
    else $error("detection fired on the unknown class");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_class < CLASS_W'(CLASS_CNT))
    else $error("winner class out of range");

  assert property (@(posedge clk) disable iff (rst)
    decide && hold_counter != '0 |=> out_suppressed)
    else $error("hop inside hold-off not marked suppressed");

  assert property (@(posedge clk) disable iff (rst)
    hops_seen <= HOPS_W'(SMOOTH_WINDOW - 1))
    else $error("hop count passed the window");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

`default_nettype wire
